>>> rtl/core/assert_macros.svh
// Assertion macros used by the dirty rectangle tracker top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("assertion failed in dirty rectangle tracker");

// The condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("assertion failed in dirty rectangle tracker");

`endif

>>> rtl/core/drt_pkg.sv
// Package with the shared constants and types of the dirty rectangle tracker.
`default_nettype none

package drt_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int COORD_BITS_DEF  = 16;

	localparam int DIM_W      = 15;
	localparam int CAP_W      = 7;
	localparam int FLAG_W     = 32;
	localparam int BATCH_W    = 16;
	localparam int CFG_DATA_W = 15;
	localparam int CFG_IDX_W  = 2;

	localparam logic [2:0] OP_INVAL      = 3'd0;
	localparam logic [2:0] OP_BATCH_BEG  = 3'd1;
	localparam logic [2:0] OP_BATCH_ITEM = 3'd2;
	localparam logic [2:0] OP_EXTENDED   = 3'd3;
	localparam logic [2:0] OP_SCREEN     = 3'd4;
	localparam logic [2:0] OP_CLEAR      = 3'd5;
	localparam logic [2:0] OP_READ_PLAIN = 3'd6;
	localparam logic [2:0] OP_READ_EXT   = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIST_CAPACITY = 2'd2;

	localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 15'd640;
	localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 15'd480;
	localparam logic [CAP_W-1:0] LIST_CAPACITY_RST = 7'd64;

	typedef struct packed {
		logic plain_we;
		logic ext_we;
		logic rd_en;
		logic rd_ext;
	} mem_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/drt_clip.sv
// Shared clip unit that clamps a rectangle to the screen and flags an empty result.
`default_nettype none

module drt_clip #(
	parameter int COORD_BITS = drt_pkg::COORD_BITS_DEF
) (
	input  wire logic signed [COORD_BITS-1:0]    in_left,
	input  wire logic signed [COORD_BITS-1:0]    in_top,
	input  wire logic signed [COORD_BITS-1:0]    in_right,
	input  wire logic signed [COORD_BITS-1:0]    in_bottom,
	input  wire logic [drt_pkg::DIM_W-1:0]       screen_width,
	input  wire logic [drt_pkg::DIM_W-1:0]       screen_height,
	output logic signed [COORD_BITS-1:0]         clip_left,
	output logic signed [COORD_BITS-1:0]         clip_top,
	output logic signed [COORD_BITS-1:0]         clip_right,
	output logic signed [COORD_BITS-1:0]         clip_bottom,
	output logic                                 nonempty
);

	localparam int CW = ((COORD_BITS > drt_pkg::DIM_W) ? COORD_BITS : drt_pkg::DIM_W) + 1;

	logic signed [CW-1:0] right_ext;
	logic signed [CW-1:0] bottom_ext;
	logic signed [CW-1:0] width_ext;
	logic signed [CW-1:0] height_ext;

	always_comb begin
		right_ext  = $signed({{(CW-COORD_BITS){in_right[COORD_BITS-1]}}, in_right});
		bottom_ext = $signed({{(CW-COORD_BITS){in_bottom[COORD_BITS-1]}}, in_bottom});
		width_ext  = $signed({{(CW-drt_pkg::DIM_W){1'b0}}, screen_width});
		height_ext = $signed({{(CW-drt_pkg::DIM_W){1'b0}}, screen_height});

		clip_left   = in_left[COORD_BITS-1] ? '0 : in_left;
		clip_top    = in_top[COORD_BITS-1] ? '0 : in_top;
		clip_right  = (right_ext > width_ext) ? $signed(width_ext[COORD_BITS-1:0]) : in_right;
		clip_bottom = (bottom_ext > height_ext) ? $signed(height_ext[COORD_BITS-1:0])
			: in_bottom;
		nonempty    = (clip_right > clip_left) && (clip_bottom > clip_top);
	end

endmodule

`default_nettype wire

>>> rtl/core/drt_store.sv
// Rectangle memories for the plain and extended lists with a registered read port.
`default_nettype none

module drt_store #(
	parameter int MAX_ENTRIES = drt_pkg::MAX_ENTRIES_DEF,
	parameter int COORD_BITS  = drt_pkg::COORD_BITS_DEF,
	parameter int AW          = 6
) (
	input  wire logic                           clk,
	input  wire drt_pkg::mem_ctl_t              ctl,
	input  wire logic [AW-1:0]                  wr_addr,
	input  wire logic [4*COORD_BITS-1:0]        wr_rect,
	input  wire logic [drt_pkg::FLAG_W-1:0]     wr_flags,
	input  wire logic [AW-1:0]                  rd_addr,
	output logic [4*COORD_BITS-1:0]             rd_rect,
	output logic [drt_pkg::FLAG_W-1:0]          rd_flags
);

	logic [4*COORD_BITS-1:0]    plain_mem [MAX_ENTRIES];
	logic [4*COORD_BITS-1:0]    ext_mem   [MAX_ENTRIES];
	logic [drt_pkg::FLAG_W-1:0] flag_mem  [MAX_ENTRIES];

	always_ff @(posedge clk) begin
		if (ctl.plain_we) begin
			plain_mem[wr_addr] <= wr_rect;
		end
		if (ctl.ext_we) begin
			ext_mem[wr_addr]  <= wr_rect;
			flag_mem[wr_addr] <= wr_flags;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			if (ctl.rd_ext) begin
				rd_rect  <= ext_mem[rd_addr];
				rd_flags <= flag_mem[rd_addr];
			end else begin
				rd_rect  <= plain_mem[rd_addr];
				rd_flags <= '0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/dirty_rectangle_tracker_top.sv
// Top level of the dirty rectangle tracker with its request sequencer.
`default_nettype none

// Each request is taken when start is high and busy is low; after the execute state its
// result appears for exactly one cycle with done high; the receiver cannot stall it, so it
// must take the result in that cycle. An extended rectangle that straddles the boundary
// row also passes a second-half state, since both halves pass in turn through the one
// shared clip unit and append one after the other to the extended list memory. Busy stays
// high until the result is out. Configuration writes are always taken and must only be
// issued while the block is idle. The list memories need no clearing after reset.
module dirty_rectangle_tracker_top #(
	parameter int MAX_ENTRIES = drt_pkg::MAX_ENTRIES_DEF,
	parameter int COORD_BITS  = drt_pkg::COORD_BITS_DEF,
	localparam int CNT_W      = $clog2(MAX_ENTRIES + 1),
	localparam int AW         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [drt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [drt_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [2:0]                        opcode,
	input  wire logic signed [COORD_BITS-1:0]      left,
	input  wire logic signed [COORD_BITS-1:0]      top,
	input  wire logic signed [COORD_BITS-1:0]      right,
	input  wire logic signed [COORD_BITS-1:0]      bottom,
	input  wire logic [drt_pkg::FLAG_W-1:0]        region_flags,
	input  wire logic signed [COORD_BITS-1:0]      boundary_row,
	input  wire logic [drt_pkg::BATCH_W-1:0]       batch_count,
	input  wire logic [AW-1:0]                     read_index,
	output logic                                   done,
	output logic                                   full_refresh,
	output logic [CNT_W-1:0]                       plain_count,
	output logic [CNT_W-1:0]                       extended_count,
	output logic                                   read_valid,
	output logic signed [COORD_BITS-1:0]           read_left,
	output logic signed [COORD_BITS-1:0]           read_top,
	output logic signed [COORD_BITS-1:0]           read_right,
	output logic signed [COORD_BITS-1:0]           read_bottom,
	output logic [drt_pkg::FLAG_W-1:0]             read_flags
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_EXT2 = 2'd2;

	localparam int CMP_W  = (CNT_W > drt_pkg::CAP_W) ? CNT_W : drt_pkg::CAP_W;
	localparam int BCMP_W = (CNT_W > drt_pkg::BATCH_W) ? CNT_W : drt_pkg::BATCH_W;

	logic [1:0]                      state_q;
	logic [2:0]                      op_q;
	logic signed [COORD_BITS-1:0]    left_q;
	logic signed [COORD_BITS-1:0]    top_q;
	logic signed [COORD_BITS-1:0]    right_q;
	logic signed [COORD_BITS-1:0]    bottom_q;
	logic signed [COORD_BITS-1:0]    row_q;
	logic [drt_pkg::FLAG_W-1:0]      flags_q;
	logic [drt_pkg::BATCH_W-1:0]     count_q;
	logic [AW-1:0]                   index_q;

	logic [CNT_W-1:0]                plain_fill_q;
	logic [CNT_W-1:0]                ext_fill_q;
	logic                            refresh_q;
	logic [drt_pkg::BATCH_W-1:0]     batch_rem_q;
	logic [drt_pkg::DIM_W-1:0]       width_q;
	logic [drt_pkg::DIM_W-1:0]       height_q;
	logic [drt_pkg::CAP_W-1:0]       capacity_q;
	logic                            done_q;
	logic                            rd_valid_q;

	logic [CMP_W-1:0]                cap_wide;
	logic [CNT_W-1:0]                cap;
	logic [CNT_W-1:0]                used;
	logic [CNT_W-1:0]                free_slots;
	logic                            plain_full;
	logic                            ext_full;
	logic                            split;
	logic                            two_halves;
	logic                            batch_ok;
	logic                            is_read;
	logic                            index_hit;

	logic signed [COORD_BITS-1:0]    cu_top;
	logic signed [COORD_BITS-1:0]    cu_bottom;
	logic signed [COORD_BITS-1:0]    cl_left;
	logic signed [COORD_BITS-1:0]    cl_top;
	logic signed [COORD_BITS-1:0]    cl_right;
	logic signed [COORD_BITS-1:0]    cl_bottom;
	logic                            cl_nonempty;

	drt_pkg::mem_ctl_t               mem_ctl;
	logic [AW-1:0]                   wr_addr;
	logic [4*COORD_BITS-1:0]         wr_rect;
	logic [4*COORD_BITS-1:0]         rd_rect;
	logic [drt_pkg::FLAG_W-1:0]      rd_flags;

	always_comb begin
		cap_wide   = CMP_W'(capacity_q);
		if (capacity_q == '0) begin
			cap = CNT_W'(1);
		end else if (cap_wide > CMP_W'(MAX_ENTRIES)) begin
			cap = CNT_W'(MAX_ENTRIES);
		end else begin
			cap = CNT_W'(cap_wide);
		end
		plain_full = plain_fill_q >= cap;
		ext_full   = ext_fill_q >= cap;
		used       = plain_full ? cap : plain_fill_q;
		free_slots = cap - used;
		split      = (top_q <= row_q) && (bottom_q > row_q);
		two_halves = (op_q == drt_pkg::OP_EXTENDED) && split;
		batch_ok   = !refresh_q && (count_q != '0) &&
			(BCMP_W'(count_q) < BCMP_W'(free_slots));
		is_read    = (op_q == drt_pkg::OP_READ_PLAIN) || (op_q == drt_pkg::OP_READ_EXT);
		index_hit  = (op_q == drt_pkg::OP_READ_EXT) ? (CNT_W'(index_q) < ext_fill_q)
			: (CNT_W'(index_q) < plain_fill_q);
	end

	always_comb begin
		cu_top    = top_q;
		cu_bottom = bottom_q;
		if (state_q == S_EXT2) begin
			cu_top = row_q;
		end else if (op_q == drt_pkg::OP_EXTENDED && split) begin
			cu_bottom = row_q;
		end
	end

	drt_clip #(
		.COORD_BITS(COORD_BITS)
	) u_clip (
		.in_left      (left_q),
		.in_top       (cu_top),
		.in_right     (right_q),
		.in_bottom    (cu_bottom),
		.screen_width (width_q),
		.screen_height(height_q),
		.clip_left    (cl_left),
		.clip_top     (cl_top),
		.clip_right   (cl_right),
		.clip_bottom  (cl_bottom),
		.nonempty     (cl_nonempty)
	);

	always_comb begin
		mem_ctl.plain_we = (state_q == S_EXEC) && !plain_full &&
			(((op_q == drt_pkg::OP_INVAL) && !refresh_q && cl_nonempty) ||
			((op_q == drt_pkg::OP_BATCH_ITEM) && (batch_rem_q != '0)));
		mem_ctl.ext_we   = (((state_q == S_EXEC) && (op_q == drt_pkg::OP_EXTENDED)) ||
			(state_q == S_EXT2)) && !ext_full && cl_nonempty;
		mem_ctl.rd_en    = (state_q == S_EXEC) && is_read;
		mem_ctl.rd_ext   = op_q == drt_pkg::OP_READ_EXT;
		if (op_q == drt_pkg::OP_BATCH_ITEM) begin
			wr_rect = {left_q, top_q, right_q, bottom_q};
		end else begin
			wr_rect = {cl_left, cl_top, cl_right, cl_bottom};
		end
		if (mem_ctl.ext_we) begin
			wr_addr = ext_fill_q[AW-1:0];
		end else begin
			wr_addr = plain_fill_q[AW-1:0];
		end
	end

	drt_store #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.COORD_BITS (COORD_BITS),
		.AW         (AW)
	) u_store (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (wr_addr),
		.wr_rect (wr_rect),
		.wr_flags(flags_q),
		.rd_addr (index_q),
		.rd_rect (rd_rect),
		.rd_flags(rd_flags)
	);

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q     <= opcode;
			left_q   <= left;
			top_q    <= top;
			right_q  <= right;
			bottom_q <= bottom;
			row_q    <= boundary_row;
			flags_q  <= region_flags;
			count_q  <= batch_count;
			index_q  <= read_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			plain_fill_q <= '0;
			ext_fill_q   <= '0;
			refresh_q    <= 1'b0;
			batch_rem_q  <= '0;
			width_q      <= drt_pkg::SCREEN_WIDTH_RST;
			height_q     <= drt_pkg::SCREEN_HEIGHT_RST;
			capacity_q   <= drt_pkg::LIST_CAPACITY_RST;
			done_q       <= 1'b0;
			rd_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					drt_pkg::REG_SCREEN_WIDTH: begin
						width_q <= cfg_data[drt_pkg::DIM_W-1:0];
					end
					drt_pkg::REG_SCREEN_HEIGHT: begin
						height_q <= cfg_data[drt_pkg::DIM_W-1:0];
					end
					drt_pkg::REG_LIST_CAPACITY: begin
						capacity_q <= cfg_data[drt_pkg::CAP_W-1:0];
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q    <= two_halves ? S_EXT2 : S_IDLE;
					done_q     <= !two_halves;
					rd_valid_q <= is_read && index_hit;
					if ((op_q != drt_pkg::OP_BATCH_ITEM) &&
						(op_q != drt_pkg::OP_BATCH_BEG)) begin
						batch_rem_q <= '0;
					end
					case (op_q)
						drt_pkg::OP_INVAL: begin
							if (!refresh_q) begin
								if (plain_full) begin
									plain_fill_q <= '0;
									ext_fill_q   <= '0;
									refresh_q    <= 1'b1;
								end else if (cl_nonempty) begin
									plain_fill_q <= plain_fill_q + CNT_W'(1);
								end
							end
						end
						drt_pkg::OP_BATCH_BEG: begin
							if (batch_ok) begin
								batch_rem_q <= count_q;
							end else begin
								batch_rem_q <= '0;
								if (!refresh_q && (count_q != '0)) begin
									plain_fill_q <= '0;
									refresh_q    <= 1'b1;
								end
							end
						end
						drt_pkg::OP_BATCH_ITEM: begin
							if (batch_rem_q != '0) begin
								batch_rem_q <= batch_rem_q - drt_pkg::BATCH_W'(1);
								if (!plain_full) begin
									plain_fill_q <= plain_fill_q + CNT_W'(1);
								end
							end
						end
						drt_pkg::OP_EXTENDED: begin
							if (ext_full) begin
								plain_fill_q <= '0;
								ext_fill_q   <= '0;
								refresh_q    <= 1'b1;
							end else if (cl_nonempty) begin
								ext_fill_q <= ext_fill_q + CNT_W'(1);
							end
						end
						drt_pkg::OP_SCREEN: begin
							plain_fill_q <= '0;
							ext_fill_q   <= '0;
							refresh_q    <= 1'b1;
						end
						drt_pkg::OP_CLEAR: begin
							plain_fill_q <= '0;
							ext_fill_q   <= '0;
							refresh_q    <= 1'b0;
						end
						default: begin
						end
					endcase
				end
				S_EXT2: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (ext_full) begin
						plain_fill_q <= '0;
						ext_fill_q   <= '0;
						refresh_q    <= 1'b1;
					end else if (cl_nonempty) begin
						ext_fill_q <= ext_fill_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign cfg_ready      = 1'b1;
	assign busy           = state_q != S_IDLE;
	assign done           = done_q;
	assign full_refresh   = refresh_q;
	assign plain_count    = plain_fill_q;
	assign extended_count = ext_fill_q;
	assign read_valid     = rd_valid_q;
	assign read_left      = rd_valid_q ? $signed(rd_rect[4*COORD_BITS-1:3*COORD_BITS]) : '0;
	assign read_top       = rd_valid_q ? $signed(rd_rect[3*COORD_BITS-1:2*COORD_BITS]) : '0;
	assign read_right     = rd_valid_q ? $signed(rd_rect[2*COORD_BITS-1:COORD_BITS]) : '0;
	assign read_bottom    = rd_valid_q ? $signed(rd_rect[COORD_BITS-1:0]) : '0;
	assign read_flags     = rd_valid_q ? rd_flags : '0;

`include "assert_macros.svh"

	`ASSERT_NEXT(a_accept_exec, start && !busy, state_q == S_EXEC)
	`ASSERT_NEXT(a_ext2_done, state_q == S_EXT2, done && !busy)
	`ASSERT_SAME(a_ext2_from_exec, state_q == S_EXT2, $past(state_q) == S_EXEC)
	`ASSERT_SAME(a_fill_bound, 1'b1,
		(plain_fill_q <= CNT_W'(MAX_ENTRIES)) && (ext_fill_q <= CNT_W'(MAX_ENTRIES)))

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for the dirty rectangle tracker: a directed table, then random phases.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = 64;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_REQUESTS = 100;
	localparam int PHASES = 8;
	localparam logic [drt_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic signed [15:0] l;
		logic signed [15:0] t;
		logic signed [15:0] r;
		logic signed [15:0] b;
	} damage_rect_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic signed [15:0] right;
		logic signed [15:0] bottom;
		logic [31:0] region_flags;
		logic signed [15:0] boundary_row;
		logic [15:0] batch_count;
		logic [5:0] read_index;
	} request_t;

	typedef struct packed {
		logic full_refresh;
		logic [6:0] plain_count;
		logic [6:0] extended_count;
		logic read_valid;
		logic signed [15:0] read_left;
		logic signed [15:0] read_top;
		logic signed [15:0] read_right;
		logic signed [15:0] read_bottom;
		logic [31:0] read_flags;
	} tracker_result_t;

	typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_e;

	typedef struct {
		row_kind_e kind;
		request_t req;
		logic [drt_pkg::CFG_IDX_W-1:0] reg_index;
		logic [drt_pkg::CFG_DATA_W-1:0] reg_data;
		bit typed;
		tracker_result_t golden;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [drt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [drt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	request_t req_q = '0;
	logic done;
	logic full_refresh;
	logic [6:0] plain_count;
	logic [6:0] extended_count;
	logic read_valid;
	logic signed [15:0] read_left;
	logic signed [15:0] read_top;
	logic signed [15:0] read_right;
	logic signed [15:0] read_bottom;
	logic [31:0] read_flags;

	damage_rect_t plain_rects [LIST_DEPTH];
	damage_rect_t ext_rects [LIST_DEPTH];
	logic [31:0] ext_flags [LIST_DEPTH];
	int plain_fill = 0;
	int ext_fill = 0;
	int batch_left = 0;
	bit refresh_all = 1'b0;
	int screen_w = drt_pkg::SCREEN_WIDTH_RST;
	int screen_h = drt_pkg::SCREEN_HEIGHT_RST;
	int capacity_reg = drt_pkg::LIST_CAPACITY_RST;

	tracker_result_t expected_results [$];
	table_row_t directed_rows [$];
	int gap_percent = 20;
	int requests_sent = 0;
	int effective_requests = 0;
	int results_checked = 0;
	int errors = 0;
	int settings_used = 1;
	int stall_cycles = 0;

	int phase_width [PHASES] = '{640, 1, 32767, 0, 100, 320, 32767, -1};
	int phase_height [PHASES] = '{480, 1, 32767, 0, 60, 200, 1, -1};
	int phase_capacity [PHASES] = '{64, 1, 64, 0, 127, 4, 2, -1};

	dirty_rectangle_tracker_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.opcode(req_q.opcode),
		.left(req_q.left),
		.top(req_q.top),
		.right(req_q.right),
		.bottom(req_q.bottom),
		.region_flags(req_q.region_flags),
		.boundary_row(req_q.boundary_row),
		.batch_count(req_q.batch_count),
		.read_index(req_q.read_index),
		.done(done),
		.full_refresh(full_refresh),
		.plain_count(plain_count),
		.extended_count(extended_count),
		.read_valid(read_valid),
		.read_left(read_left),
		.read_top(read_top),
		.read_right(read_right),
		.read_bottom(read_bottom),
		.read_flags(read_flags)
	);

	always #2 clk = ~clk;

	function automatic int capacity_limit();
		if (capacity_reg == 0)
			return 1;
		if (capacity_reg > LIST_DEPTH)
			return LIST_DEPTH;
		return capacity_reg;
	endfunction

	function automatic bit clip_to_screen(input int l, t, r, b, output damage_rect_t q);
		if (l < 0)
			l = 0;
		if (t < 0)
			t = 0;
		if (r > screen_w)
			r = screen_w;
		if (b > screen_h)
			b = screen_h;
		q.l = 16'(l);
		q.t = 16'(t);
		q.r = 16'(r);
		q.b = 16'(b);
		return r > l && b > t;
	endfunction

	function automatic void mark_overflow();
		plain_fill = 0;
		ext_fill = 0;
		refresh_all = 1'b1;
	endfunction

	function automatic void append_extended(input int l, t, r, b, input logic [31:0] fl);
		damage_rect_t q;
		if (ext_fill >= capacity_limit()) begin
			mark_overflow();
		end else if (clip_to_screen(l, t, r, b, q)) begin
			ext_rects[ext_fill] = q;
			ext_flags[ext_fill] = fl;
			ext_fill++;
		end
	endfunction

	function automatic tracker_result_t predict_request(input request_t rq, output bit ignored);
		int l, t, r, b, row, cap, used;
		damage_rect_t q;
		damage_rect_t rd;
		tracker_result_t res;
		l = $signed(rq.left);
		t = $signed(rq.top);
		r = $signed(rq.right);
		b = $signed(rq.bottom);
		row = $signed(rq.boundary_row);
		cap = capacity_limit();
		res = '0;
		rd = '0;
		ignored = 1'b0;
		if (rq.opcode != drt_pkg::OP_BATCH_ITEM)
			batch_left = 0;
		case (rq.opcode)
			drt_pkg::OP_INVAL: begin
				if (refresh_all) begin
					ignored = 1'b1;
				end else if (plain_fill >= cap) begin
					mark_overflow();
				end else if (clip_to_screen(l, t, r, b, q)) begin
					plain_rects[plain_fill] = q;
					plain_fill++;
				end
			end
			drt_pkg::OP_BATCH_BEG: begin
				used = (plain_fill < cap) ? plain_fill : cap;
				if (refresh_all || rq.batch_count == 0) begin
					ignored = 1'b1;
				end else if (int'(rq.batch_count) < cap - used) begin
					batch_left = rq.batch_count;
				end else begin
					plain_fill = 0;
					refresh_all = 1'b1;
				end
			end
			drt_pkg::OP_BATCH_ITEM: begin
				if (batch_left == 0) begin
					ignored = 1'b1;
				end else begin
					batch_left--;
					if (plain_fill < cap) begin
						plain_rects[plain_fill] = {rq.left, rq.top, rq.right, rq.bottom};
						plain_fill++;
					end
				end
			end
			drt_pkg::OP_EXTENDED: begin
				if (t <= row && b > row) begin
					append_extended(l, t, r, row, rq.region_flags);
					append_extended(l, row, r, b, rq.region_flags);
				end else begin
					append_extended(l, t, r, b, rq.region_flags);
				end
			end
			drt_pkg::OP_SCREEN: mark_overflow();
			drt_pkg::OP_CLEAR: begin
				plain_fill = 0;
				ext_fill = 0;
				refresh_all = 1'b0;
			end
			drt_pkg::OP_READ_PLAIN: begin
				if (int'(rq.read_index) < plain_fill) begin
					res.read_valid = 1'b1;
					rd = plain_rects[rq.read_index];
				end
			end
			default: begin
				if (int'(rq.read_index) < ext_fill) begin
					res.read_valid = 1'b1;
					rd = ext_rects[rq.read_index];
					res.read_flags = ext_flags[rq.read_index];
				end
			end
		endcase
		res.read_left = rd.l;
		res.read_top = rd.t;
		res.read_right = rd.r;
		res.read_bottom = rd.b;
		res.full_refresh = refresh_all;
		res.plain_count = 7'(plain_fill);
		res.extended_count = 7'(ext_fill);
		return res;
	endfunction

	function automatic void compare_field(input string name, input logic signed [63:0] exp_v,
			input logic signed [63:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	function automatic void add_request(input logic [2:0] op, input int l, t, r, b,
			input logic [31:0] fl, input int row, input int cnt, input int idx);
		table_row_t e;
		e.kind = ROW_REQUEST;
		e.req = '0;
		e.req.opcode = op;
		e.req.left = 16'(l);
		e.req.top = 16'(t);
		e.req.right = 16'(r);
		e.req.bottom = 16'(b);
		e.req.region_flags = fl;
		e.req.boundary_row = 16'(row);
		e.req.batch_count = 16'(cnt);
		e.req.read_index = 6'(idx);
		e.reg_index = '0;
		e.reg_data = '0;
		e.typed = 1'b0;
		e.golden = '0;
		directed_rows.insert(directed_rows.size(), e);
	endfunction

	function automatic void set_golden(input bit fr, input int pc, ec, input bit rv,
			input int rl, rt, rr, rb, input logic [31:0] rf);
		int last;
		last = directed_rows.size() - 1;
		directed_rows[last].typed = 1'b1;
		directed_rows[last].golden = {fr, 7'(pc), 7'(ec), rv, 16'(rl), 16'(rt), 16'(rr),
			16'(rb), rf};
	endfunction

	function automatic void add_register(input logic [drt_pkg::CFG_IDX_W-1:0] idx,
			input int data);
		table_row_t e;
		e.kind = ROW_REGISTER;
		e.req = '0;
		e.reg_index = idx;
		e.reg_data = drt_pkg::CFG_DATA_W'(data);
		e.typed = 1'b0;
		e.golden = '0;
		directed_rows.insert(directed_rows.size(), e);
	endfunction

	function automatic int random_coord(input int extent);
		if ($urandom_range(0, 99) < 12)
			return $signed(16'($urandom()));
		return int'($urandom_range(0, extent + 40)) - 20;
	endfunction

	function automatic request_t random_request();
		request_t rq;
		int a, c;
		rq = '0;
		rq.opcode = 3'($urandom_range(0, 7));
		a = random_coord(screen_w);
		c = random_coord(screen_w);
		if (a > c && $urandom_range(0, 99) < 85) begin
			rq.left = 16'(c);
			rq.right = 16'(a);
		end else begin
			rq.left = 16'(a);
			rq.right = 16'(c);
		end
		a = random_coord(screen_h);
		c = random_coord(screen_h);
		if (a > c && $urandom_range(0, 99) < 85) begin
			a = a + c;
			c = a - c;
			a = a - c;
		end
		rq.top = 16'(a);
		rq.bottom = 16'(c);
		if ($signed(rq.bottom) > $signed(rq.top) && $urandom_range(0, 99) < 70)
			rq.boundary_row = 16'(int'($signed(rq.top))
				+ int'($urandom_range(0, int'($signed(rq.bottom)) - int'($signed(rq.top)) - 1)));
		else
			rq.boundary_row = 16'(random_coord(screen_h));
		rq.region_flags = $urandom();
		rq.batch_count = 16'($urandom());
		rq.read_index = 6'($urandom());
		return rq;
	endfunction

	task automatic send_request(input request_t rq, input bit has_golden,
			input tracker_result_t golden);
		tracker_result_t predicted;
		bit ignored;
		start <= 1'b1;
		req_q <= rq;
		do @(posedge clk); while (busy);
		predicted = predict_request(rq, ignored);
		expected_results.insert(expected_results.size(), has_golden ? golden : predicted);
		requests_sent++;
		if (!ignored)
			effective_requests++;
		if ($urandom_range(0, 99) < gap_percent) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic write_register(input logic [drt_pkg::CFG_IDX_W-1:0] idx,
			input logic [drt_pkg::CFG_DATA_W-1:0] data);
		start <= 1'b0;
		while (expected_results.size() != 0 || busy)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			drt_pkg::REG_SCREEN_WIDTH: screen_w = data;
			drt_pkg::REG_SCREEN_HEIGHT: screen_h = data;
			drt_pkg::REG_LIST_CAPACITY: capacity_reg = data[drt_pkg::CAP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic run_random_phase(input int target);
		request_t rq;
		request_t item;
		logic [159:0] raw;
		int first, pick, free, n, fill;
		first = effective_requests;
		while (effective_requests - first < target) begin
			pick = $urandom_range(0, 99);
			rq = random_request();
			if (refresh_all && $urandom_range(0, 99) < 25) begin
				rq.opcode = drt_pkg::OP_CLEAR;
			end else if (pick < 24) begin
				rq.opcode = drt_pkg::OP_INVAL;
			end else if (pick < 38) begin
				rq.opcode = drt_pkg::OP_BATCH_BEG;
				free = capacity_limit() - ((plain_fill < capacity_limit()) ?
					plain_fill : capacity_limit());
				if ($urandom_range(0, 99) < 85)
					rq.batch_count = 16'($urandom_range(1,
						(free > 2) ? ((free > 9) ? 8 : free - 1) : 1));
				send_request(rq, 1'b0, '0);
				n = (batch_left < rq.batch_count) ? batch_left : rq.batch_count;
				if ($urandom_range(0, 99) < 10)
					n = $urandom_range(0, n);
				repeat (n) begin
					item = random_request();
					item.opcode = drt_pkg::OP_BATCH_ITEM;
					send_request(item, 1'b0, '0);
				end
				continue;
			end else if (pick < 56) begin
				rq.opcode = drt_pkg::OP_EXTENDED;
			end else if (pick < 59) begin
				rq.opcode = drt_pkg::OP_SCREEN;
			end else if (pick < 66) begin
				rq.opcode = drt_pkg::OP_CLEAR;
			end else if (pick < 90) begin
				rq.opcode = (pick < 78) ? drt_pkg::OP_READ_PLAIN : drt_pkg::OP_READ_EXT;
				fill = (rq.opcode == drt_pkg::OP_READ_EXT) ? ext_fill : plain_fill;
				if ($urandom_range(0, 99) < 75)
					rq.read_index = 6'($urandom_range(0, fill));
			end else if (pick < 93) begin
				rq.opcode = drt_pkg::OP_BATCH_ITEM;
			end else begin
				raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
				rq = raw[$bits(request_t)-1:0];
			end
			send_request(rq, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin : result_check
		tracker_result_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result arrived with no request outstanding");
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				compare_field("full_refresh", exp_r.full_refresh, full_refresh);
				compare_field("plain_count", exp_r.plain_count, plain_count);
				compare_field("extended_count", exp_r.extended_count, extended_count);
				compare_field("read_valid", exp_r.read_valid, read_valid);
				compare_field("read_left", exp_r.read_left, read_left);
				compare_field("read_top", exp_r.read_top, read_top);
				compare_field("read_right", exp_r.read_right, read_right);
				compare_field("read_bottom", exp_r.read_bottom, read_bottom);
				compare_field("read_flags", exp_r.read_flags, read_flags);
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		add_request(drt_pkg::OP_READ_PLAIN, 0, 0, 0, 0, 0, 0, 0, 0);
		set_golden(0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_request(drt_pkg::OP_INVAL, -32768, -32768, 32767, 32767, 0, 0, 0, 0);
		set_golden(0, 1, 0, 0, 0, 0, 0, 0, 0);
		add_request(drt_pkg::OP_READ_PLAIN, 0, 0, 0, 0, 0, 0, 0, 0);
		set_golden(0, 1, 0, 1, 0, 0, 640, 480, 0);
		add_request(drt_pkg::OP_INVAL, 10, 10, 10, 20, 0, 0, 0, 0);
		add_request(drt_pkg::OP_INVAL, 700, 0, 800, 10, 0, 0, 0, 0);
		add_request(drt_pkg::OP_EXTENDED, 0, 0, 100, 100, 32'hFFFF_FFFF, 50, 0, 0);
		add_request(drt_pkg::OP_READ_EXT, 0, 0, 0, 0, 0, 0, 0, 1);
		set_golden(0, 1, 2, 1, 0, 50, 100, 100, 32'hFFFF_FFFF);
		add_request(drt_pkg::OP_EXTENDED, -5, 10, 30, 40, 32'hA5A5_5A5A, -32768, 0, 0);
		add_request(drt_pkg::OP_EXTENDED, 0, 0, 20, 20, 0, 20, 0, 0);
		add_request(drt_pkg::OP_EXTENDED, 0, 20, 20, 40, 32'h0000_0001, 20, 0, 0);
		add_request(drt_pkg::OP_READ_EXT, 0, 0, 0, 0, 0, 0, 0, 63);
		add_request(drt_pkg::OP_BATCH_BEG, 0, 0, 0, 0, 0, 0, 0, 0);
		add_request(drt_pkg::OP_BATCH_BEG, 0, 0, 0, 0, 0, 0, 3, 0);
		add_request(drt_pkg::OP_BATCH_ITEM, -32768, -32768, 32767, 32767, 0, 0, 0, 0);
		add_request(drt_pkg::OP_READ_PLAIN, 0, 0, 0, 0, 0, 0, 0, 1);
		set_golden(0, 2, 5, 1, -32768, -32768, 32767, 32767, 0);
		add_request(drt_pkg::OP_BATCH_ITEM, 1, 2, 3, 4, 0, 0, 0, 0);
		add_request(drt_pkg::OP_BATCH_BEG, 0, 0, 0, 0, 0, 0, 65535, 0);
		add_request(drt_pkg::OP_INVAL, 0, 0, 10, 10, 0, 0, 0, 0);
		add_request(drt_pkg::OP_EXTENDED, 0, 0, 10, 10, 32'h8000_0000, -1, 0, 0);
		add_request(drt_pkg::OP_SCREEN, 0, 0, 0, 0, 0, 0, 0, 0);
		set_golden(1, 0, 0, 0, 0, 0, 0, 0, 0);
		add_request(drt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
		set_golden(0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_register(drt_pkg::REG_LIST_CAPACITY, 1);
		add_request(drt_pkg::OP_INVAL, 0, 0, 5, 5, 0, 0, 0, 0);
		add_request(drt_pkg::OP_INVAL, 0, 0, 5, 5, 0, 0, 0, 0);
		set_golden(1, 0, 0, 0, 0, 0, 0, 0, 0);
		add_request(drt_pkg::OP_EXTENDED, 0, 0, 8, 8, 32'h0F0F_0F0F, 100, 0, 0);
		add_request(drt_pkg::OP_EXTENDED, 0, 0, 8, 8, 32'hF0F0_F0F0, 4, 0, 0);
		add_request(drt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
		add_register(drt_pkg::REG_LIST_CAPACITY, 64);
		add_request(drt_pkg::OP_BATCH_BEG, 0, 0, 0, 0, 0, 0, 5, 0);
		add_register(drt_pkg::REG_LIST_CAPACITY, 1);
		add_request(drt_pkg::OP_BATCH_ITEM, 0, 0, 1, 1, 0, 0, 0, 0);
		add_request(drt_pkg::OP_BATCH_ITEM, -9, -9, -1, -1, 0, 0, 0, 0);
		add_request(drt_pkg::OP_BATCH_BEG, 0, 0, 0, 0, 0, 0, 1, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REGISTER) begin
				write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
				settings_used++;
			end else begin
				send_request(directed_rows[i].req, directed_rows[i].typed,
					directed_rows[i].golden);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			write_register(drt_pkg::REG_SCREEN_WIDTH, (phase_width[p] < 0) ?
				drt_pkg::CFG_DATA_W'($urandom_range(0, 32767)) :
				drt_pkg::CFG_DATA_W'(phase_width[p]));
			write_register(drt_pkg::REG_SCREEN_HEIGHT, (phase_height[p] < 0) ?
				drt_pkg::CFG_DATA_W'($urandom_range(0, 32767)) :
				drt_pkg::CFG_DATA_W'(phase_height[p]));
			write_register(drt_pkg::REG_LIST_CAPACITY, {8'($urandom()),
				(phase_capacity[p] < 0) ? 7'($urandom()) : 7'(phase_capacity[p])});
			if (p == 4)
				write_register(REG_SPARE, drt_pkg::CFG_DATA_W'($urandom()));
			settings_used++;
			gap_percent = (p == 2) ? 0 : 20;
			run_random_phase(PHASE_REQUESTS);
		end

		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d requests (%0d took effect), checked %0d results, %0d register settings.",
			requests_sent, effective_requests, results_checked, settings_used);
		$display("Settings ranged over one-entry lists, zero and maximal screens, wide capacity codes.");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/drt_pkg.sv
rtl/core/drt_clip.sv
rtl/core/drt_store.sv
rtl/core/dirty_rectangle_tracker_top.sv
test/testbench.sv
